@@ design/utf8v_pkg.sv @@
// Shared types and constants of the UTF-8 string validator.
package utf8v_pkg;

    localparam int unsigned COUNT_W  = 21;
    localparam int unsigned CFG_W    = 21;
    localparam int unsigned RNG_W    = 3;
    localparam int unsigned PEND_W   = 2;
    localparam int unsigned NUM_RNG  = 5;
    localparam int unsigned Q_DEPTH  = 2;
    localparam int unsigned Q_AW     = $clog2(Q_DEPTH);
    localparam int unsigned Q_CW     = $clog2(Q_DEPTH + 1);
    localparam int unsigned LIMIT_W  = 25;

    localparam logic [COUNT_W-1:0] COUNT_TOP        = {COUNT_W{1'b1}};
    localparam logic [LIMIT_W-1:0] MAX_STRING_LIMIT = 25'd1048576;
    localparam logic [COUNT_W-1:0] MAX_BYTES_RST    = 21'd1048576;
    localparam logic               REJECT_NUL_RST   = 1'b1;

    localparam logic CFG_IDX_MAX_BYTES  = 1'b0;
    localparam logic CFG_IDX_REJECT_NUL = 1'b1;

    localparam logic [RNG_W-1:0] RNG_80_BF = 3'd0;
    localparam logic [RNG_W-1:0] RNG_A0_BF = 3'd1;
    localparam logic [RNG_W-1:0] RNG_80_9F = 3'd2;
    localparam logic [RNG_W-1:0] RNG_90_BF = 3'd3;
    localparam logic [RNG_W-1:0] RNG_80_8F = 3'd4;

    localparam logic [7:0] B_ASCII_MAX = 8'h7f;
    localparam logic [7:0] B_L2_MIN    = 8'hc2;
    localparam logic [7:0] B_L2_MAX    = 8'hdf;
    localparam logic [7:0] B_L3_MIN    = 8'he0;
    localparam logic [7:0] B_L3_MAX    = 8'hef;
    localparam logic [7:0] B_L3_SURR   = 8'hed;
    localparam logic [7:0] B_L4_MIN    = 8'hf0;
    localparam logic [7:0] B_L4_MAX    = 8'hf4;
    localparam logic [7:0] B_CONT_MIN  = 8'h80;
    localparam logic [7:0] B_CONT_MAX  = 8'hbf;
    localparam logic [7:0] B_A0        = 8'ha0;
    localparam logic [7:0] B_9F        = 8'h9f;
    localparam logic [7:0] B_90        = 8'h90;
    localparam logic [7:0] B_8F        = 8'h8f;

    typedef struct packed {
        logic                has_byte;
        logic                last;
        logic                is_zero;
        logic                bad_lead;
        logic [PEND_W-1:0]   pend;
        logic [RNG_W-1:0]    rng;
        logic [NUM_RNG-1:0]  rng_ok;
    } t_cls;

endpackage

@@ design/utf8_string_validator_top.sv @@
// Top level of the strict UTF-8 string validator.
// Takes one byte per cycle on the slave stream while tready is high and gives
// one verdict per string on the master stream. The verdict register loads at
// the clock edge where the item marked tlast leaves the two-entry queue
// between the byte classifier and the sequence checker. With the queue empty,
// that item goes through a queue entry into the verdict register, and tvalid
// rises. Sustained rate is one item per clock while no verdict waits unread.
// A verdict waiting in the output register holds the next tlast item at the
// head of the queue. Items behind it fill the queue, and then tready drops
// until the verdict is taken. Configuration writes take effect at once.
module utf8_string_validator_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic                        i_cfg_addr,
    input  logic [utf8v_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [7:0]                  i_s_axis_tdata,   // [7:0] byte_value
    input  logic                        i_s_axis_tuser,   // [0] has_byte
    input  logic                        i_s_axis_tlast,   // last_byte
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [7:0]                  o_m_axis_tdata    // [0] valid_res, [7:1] zero
);

    utf8v_pkg::t_cls cls;
    utf8v_pkg::t_cls q_data;
    logic            q_full;
    logic            q_valid;
    logic            q_pop;
    logic            push;
    logic            res;

    assign o_s_axis_tready = !q_full;
    assign push            = i_s_axis_tvalid && !q_full;
    assign o_m_axis_tdata  = {7'b0, res};

    utf8v_front u_front (
        .i_byte     (i_s_axis_tdata),
        .i_has_byte (i_s_axis_tuser),
        .i_last     (i_s_axis_tlast),
        .o_cls      (cls)
    );

    utf8v_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cls),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    utf8v_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (q_valid),
        .i_q_data    (q_data),
        .o_q_pop     (q_pop),
        .o_res_valid (o_m_axis_tvalid),
        .o_res       (res),
        .i_res_ready (i_m_axis_tready)
    );

endmodule

@@ design/utf8v_front.sv @@
// Front end: classifies each incoming byte for the sequence checker.
module utf8v_front (
    input  logic [7:0]     i_byte,
    input  logic           i_has_byte,
    input  logic           i_last,
    output utf8v_pkg::t_cls o_cls
);

    logic is_cont;

    always_comb begin
        is_cont = (i_byte >= utf8v_pkg::B_CONT_MIN) && (i_byte <= utf8v_pkg::B_CONT_MAX);

        o_cls.has_byte = i_has_byte;
        o_cls.last     = i_last;
        o_cls.is_zero  = (i_byte == 8'h00);
        o_cls.bad_lead = 1'b0;
        o_cls.pend     = '0;
        o_cls.rng      = utf8v_pkg::RNG_80_BF;

        o_cls.rng_ok[utf8v_pkg::RNG_80_BF] = is_cont;
        o_cls.rng_ok[utf8v_pkg::RNG_A0_BF] = is_cont && (i_byte >= utf8v_pkg::B_A0);
        o_cls.rng_ok[utf8v_pkg::RNG_80_9F] = is_cont && (i_byte <= utf8v_pkg::B_9F);
        o_cls.rng_ok[utf8v_pkg::RNG_90_BF] = is_cont && (i_byte >= utf8v_pkg::B_90);
        o_cls.rng_ok[utf8v_pkg::RNG_80_8F] = is_cont && (i_byte <= utf8v_pkg::B_8F);

        if (i_byte <= utf8v_pkg::B_ASCII_MAX) begin
            o_cls.pend = 2'd0;
        end else if (i_byte >= utf8v_pkg::B_L2_MIN && i_byte <= utf8v_pkg::B_L2_MAX) begin
            o_cls.pend = 2'd1;
        end else if (i_byte >= utf8v_pkg::B_L3_MIN && i_byte <= utf8v_pkg::B_L3_MAX) begin
            o_cls.pend = 2'd2;
            if (i_byte == utf8v_pkg::B_L3_MIN) begin
                o_cls.rng = utf8v_pkg::RNG_A0_BF;
            end else if (i_byte == utf8v_pkg::B_L3_SURR) begin
                o_cls.rng = utf8v_pkg::RNG_80_9F;
            end
        end else if (i_byte >= utf8v_pkg::B_L4_MIN && i_byte <= utf8v_pkg::B_L4_MAX) begin
            o_cls.pend = 2'd3;
            if (i_byte == utf8v_pkg::B_L4_MIN) begin
                o_cls.rng = utf8v_pkg::RNG_90_BF;
            end else if (i_byte == utf8v_pkg::B_L4_MAX) begin
                o_cls.rng = utf8v_pkg::RNG_80_8F;
            end
        end else begin
            o_cls.bad_lead = 1'b1;
        end
    end

endmodule

@@ design/utf8v_queue.sv @@
// Two-entry queue of classified items between front end and checker.
module utf8v_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  utf8v_pkg::t_cls i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output utf8v_pkg::t_cls o_data
);

    utf8v_pkg::t_cls r_mem [utf8v_pkg::Q_DEPTH];
    logic [utf8v_pkg::Q_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [utf8v_pkg::Q_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [utf8v_pkg::Q_CW-1:0] r_count, n_count;

    assign o_full  = (r_count == utf8v_pkg::Q_CW'(utf8v_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == utf8v_pkg::Q_AW'(utf8v_pkg::Q_DEPTH - 1)) ? '0
                                                                               : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == utf8v_pkg::Q_AW'(utf8v_pkg::Q_DEPTH - 1)) ? '0
                                                                               : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ design/utf8v_back.sv @@
// Back end: sequence state, byte count, configuration and verdict register.
module utf8v_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic                               i_cfg_addr,
    input  logic [utf8v_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  logic                               i_q_valid,
    input  utf8v_pkg::t_cls                    i_q_data,
    output logic                               o_q_pop,
    output logic                               o_res_valid,
    output logic                               o_res,
    input  logic                               i_res_ready
);

    logic [utf8v_pkg::COUNT_W-1:0] r_max_bytes;
    logic                          r_reject_nul;

    logic [utf8v_pkg::PEND_W-1:0]  r_pend, n_pend;
    logic [utf8v_pkg::RNG_W-1:0]   r_rng, n_rng;
    logic                          r_fail, n_fail;
    logic [utf8v_pkg::COUNT_W-1:0] r_count, n_count;
    logic                          r_res_valid, n_res_valid;
    logic                          r_res, n_res;
    logic                          rng_ok;
    logic                          ok;

    assign o_q_pop     = i_q_valid && (!i_q_data.last || !r_res_valid || i_res_ready);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_comb begin
        unique case (r_rng)
            utf8v_pkg::RNG_80_BF: rng_ok = i_q_data.rng_ok[utf8v_pkg::RNG_80_BF];
            utf8v_pkg::RNG_A0_BF: rng_ok = i_q_data.rng_ok[utf8v_pkg::RNG_A0_BF];
            utf8v_pkg::RNG_80_9F: rng_ok = i_q_data.rng_ok[utf8v_pkg::RNG_80_9F];
            utf8v_pkg::RNG_90_BF: rng_ok = i_q_data.rng_ok[utf8v_pkg::RNG_90_BF];
            utf8v_pkg::RNG_80_8F: rng_ok = i_q_data.rng_ok[utf8v_pkg::RNG_80_8F];
            default:              rng_ok = 1'b0;
        endcase
    end

    always_comb begin
        n_pend      = r_pend;
        n_rng       = r_rng;
        n_fail      = r_fail;
        n_count     = r_count;
        n_res_valid = r_res_valid && !i_res_ready;
        n_res       = r_res;
        ok          = 1'b0;

        if (o_q_pop) begin
            if (i_q_data.has_byte) begin
                if (r_count != utf8v_pkg::COUNT_TOP) begin
                    n_count = r_count + 1'b1;
                end
                if (r_reject_nul && i_q_data.is_zero) begin
                    n_fail = 1'b1;
                end
                if (n_fail) begin
                    n_pend = '0;
                    n_rng  = utf8v_pkg::RNG_80_BF;
                end else if (r_pend != '0) begin
                    n_fail = !rng_ok;
                    n_pend = r_pend - 1'b1;
                    n_rng  = utf8v_pkg::RNG_80_BF;
                end else if (i_q_data.bad_lead) begin
                    n_fail = 1'b1;
                end else begin
                    n_pend = i_q_data.pend;
                    n_rng  = i_q_data.rng;
                end
            end

            if (i_q_data.last) begin
                ok = !n_fail && (n_pend == '0) && (n_count != utf8v_pkg::COUNT_TOP) &&
                     (n_count <= r_max_bytes) &&
                     ({{(utf8v_pkg::LIMIT_W - utf8v_pkg::COUNT_W){1'b0}}, n_count}
                        <= utf8v_pkg::MAX_STRING_LIMIT);
                n_res_valid = 1'b1;
                n_res       = ok;
                n_pend      = '0;
                n_rng       = utf8v_pkg::RNG_80_BF;
                n_fail      = 1'b0;
                n_count     = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes  <= utf8v_pkg::MAX_BYTES_RST;
            r_reject_nul <= utf8v_pkg::REJECT_NUL_RST;
            r_pend       <= '0;
            r_rng        <= utf8v_pkg::RNG_80_BF;
            r_fail       <= 1'b0;
            r_count      <= '0;
            r_res_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_addr)
                    utf8v_pkg::CFG_IDX_MAX_BYTES:  r_max_bytes  <= i_cfg_wdata;
                    utf8v_pkg::CFG_IDX_REJECT_NUL: r_reject_nul <= i_cfg_wdata[0];
                    default:                       r_reject_nul <= r_reject_nul;
                endcase
            end
            r_pend      <= n_pend;
            r_rng       <= n_rng;
            r_fail      <= n_fail;
            r_count     <= n_count;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

endmodule

@@ design/utf8v_checker.sv @@
// Port-level checks of the UTF-8 string validator, bound to the top level.
module utf8v_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_axis_tvalid,
    input logic       o_s_axis_tready,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("verdict dropped or changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("block not empty after reset");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[7:1] == 7'b0)
        else $error("verdict padding bits not zero");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(!o_s_axis_tready) || $past(i_s_axis_tvalid, 2)
            || $past(o_m_axis_tvalid, 2) || !$past(o_s_axis_tready, 2)
            || $past(i_s_axis_tvalid, 3))
        else $error("verdict appeared without an earlier item");

endmodule

bind utf8_string_validator_top utf8v_checker u_utf8v_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

@@ tb/tb.sv @@
// UTF-8 string validator bench: set verdicts for directed strings, a predictor for random ones.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import utf8v_pkg::*;

    localparam int IDLE_LIMIT    = 1000;
    localparam int SETTLE_CYCLES = 10;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 150;

    localparam logic [1:0] V_FAIL  = 2'd0;
    localparam logic [1:0] V_PASS  = 2'd1;
    localparam logic [1:0] V_MODEL = 2'd2;

    typedef struct packed {
        logic [7:0] value;
        logic       has;
        logic       last;
    } str_item_t;

    typedef struct packed {
        str_item_t  it;
        logic [1:0] verdict;
    } dir_row_t;

    dir_row_t dir_rows [25] = '{
        {8'h00, 1'b0, 1'b1, V_PASS},
        {8'h41, 1'b1, 1'b0, V_MODEL},
        {8'h5a, 1'b0, 1'b0, V_MODEL},
        {8'h00, 1'b0, 1'b1, V_PASS},
        {8'h00, 1'b1, 1'b1, V_FAIL},
        {8'h7f, 1'b1, 1'b1, V_PASS},
        {8'hc2, 1'b1, 1'b0, V_MODEL},
        {8'h80, 1'b1, 1'b1, V_PASS},
        {8'hc1, 1'b1, 1'b1, V_FAIL},
        {8'hff, 1'b1, 1'b1, V_FAIL},
        {8'he0, 1'b1, 1'b0, V_MODEL},
        {8'h9f, 1'b1, 1'b0, V_MODEL},
        {8'h80, 1'b1, 1'b1, V_FAIL},
        {8'hed, 1'b1, 1'b0, V_MODEL},
        {8'ha0, 1'b1, 1'b0, V_MODEL},
        {8'h80, 1'b1, 1'b1, V_FAIL},
        {8'hf4, 1'b1, 1'b0, V_MODEL},
        {8'h90, 1'b1, 1'b0, V_MODEL},
        {8'h80, 1'b1, 1'b0, V_MODEL},
        {8'h80, 1'b1, 1'b1, V_FAIL},
        {8'hf4, 1'b1, 1'b0, V_MODEL},
        {8'h8f, 1'b1, 1'b0, V_MODEL},
        {8'hbf, 1'b1, 1'b0, V_MODEL},
        {8'hbf, 1'b1, 1'b1, V_PASS},
        {8'hdf, 1'b1, 1'b1, V_FAIL}
    };

    logic             i_clk     = 1'b0;
    logic             i_rst_n   = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic             cfg_addr  = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             s_tvalid  = 1'b0;
    logic [7:0]       s_tdata   = 8'h00;
    logic             s_tuser   = 1'b0;
    logic             s_tlast   = 1'b0;
    logic             m_tready  = 1'b0;
    logic             o_s_axis_tready;
    logic             o_m_axis_tvalid;
    logic [7:0]       o_m_axis_tdata;

    logic [PEND_W-1:0]  p_pend       = '0;
    logic [RNG_W-1:0]   p_rng        = RNG_80_BF;
    logic               p_failed     = 1'b0;
    logic [COUNT_W-1:0] p_count      = '0;
    logic [CFG_W-1:0]   p_max_bytes  = MAX_BYTES_RST;
    logic               p_reject_nul = REJECT_NUL_RST;

    logic      verdict_q [$];
    str_item_t feed_q [$];
    logic [7:0] text_bytes [$];

    int mismatches   = 0;
    int quiet_cycles = 0;
    int string_items = 0;
    int s_gap_max    = 16;
    int m_gap_max    = 16;

    utf8_string_validator_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic cont_in_range(logic [7:0] b, logic [RNG_W-1:0] r);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = B_CONT_MIN;
        hi = B_CONT_MAX;
        case (r)
            RNG_A0_BF: lo = B_A0;
            RNG_80_9F: hi = B_9F;
            RNG_90_BF: lo = B_90;
            RNG_80_8F: hi = B_8F;
            default: ;
        endcase
        return (b >= lo) && (b <= hi);
    endfunction

    function automatic logic [RNG_W-1:0] second_range(logic [7:0] lead);
        if (lead == B_L3_MIN) return RNG_A0_BF;
        if (lead == B_L3_SURR) return RNG_80_9F;
        if (lead == B_L4_MIN) return RNG_90_BF;
        if (lead == B_L4_MAX) return RNG_80_8F;
        return RNG_80_BF;
    endfunction

    function automatic logic [7:0] rand_cont(logic [RNG_W-1:0] r);
        case (r)
            RNG_A0_BF: return 8'($urandom_range(B_A0, B_CONT_MAX));
            RNG_80_9F: return 8'($urandom_range(B_CONT_MIN, B_9F));
            RNG_90_BF: return 8'($urandom_range(B_90, B_CONT_MAX));
            RNG_80_8F: return 8'($urandom_range(B_CONT_MIN, B_8F));
            default:   return 8'($urandom_range(B_CONT_MIN, B_CONT_MAX));
        endcase
    endfunction

    task automatic verdict_step(input str_item_t it, output logic has_verdict,
                                output logic verdict);
        logic [LIMIT_W-1:0] lim;
        has_verdict = 1'b0;
        verdict = 1'b0;
        if (it.has) begin
            if (p_count != COUNT_TOP) p_count = p_count + 1'b1;
            if (p_reject_nul && it.value == 8'h00) p_failed = 1'b1;
            if (p_failed) begin
                p_pend = '0;
                p_rng = RNG_80_BF;
            end else if (p_pend != '0) begin
                if (!cont_in_range(it.value, p_rng)) p_failed = 1'b1;
                p_pend = p_pend - 1'b1;
                p_rng = RNG_80_BF;
            end else if (it.value >= B_L2_MIN && it.value <= B_L2_MAX) begin
                p_pend = 2'd1;
                p_rng = RNG_80_BF;
            end else if (it.value >= B_L3_MIN && it.value <= B_L3_MAX) begin
                p_pend = 2'd2;
                p_rng = second_range(it.value);
            end else if (it.value >= B_L4_MIN && it.value <= B_L4_MAX) begin
                p_pend = 2'd3;
                p_rng = second_range(it.value);
            end else if (it.value > B_ASCII_MAX) begin
                p_failed = 1'b1;
            end
        end
        if (it.last) begin
            lim = (LIMIT_W'(p_max_bytes) > MAX_STRING_LIMIT) ? MAX_STRING_LIMIT
                                                             : LIMIT_W'(p_max_bytes);
            has_verdict = 1'b1;
            verdict = !p_failed && p_pend == '0 && p_count != COUNT_TOP &&
                      LIMIT_W'(p_count) <= lim;
            p_pend = '0;
            p_rng = RNG_80_BF;
            p_failed = 1'b0;
            p_count = '0;
        end
    endtask

    task automatic send_item(input str_item_t it, input logic [1:0] typed);
        int   gap;
        logic hv;
        logic v;
        gap = $urandom_range(0, s_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it.value;
        s_tuser  <= it.has;
        s_tlast  <= it.last;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        verdict_step(it, hv, v);
        if (hv) verdict_q.push_back((typed == V_MODEL) ? v : typed[0]);
        if (it.has || it.last) string_items++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_IDX_MAX_BYTES) p_max_bytes = val;
        else p_reject_nul = val[0];
    endtask

    // Mostly well-formed code points, some mutated, some raw noise.
    task automatic build_string();
        int         n_cp;
        int         pos;
        logic       end_marker;
        logic [7:0] lead;
        text_bytes.delete();
        n_cp = $urandom_range(0, 6);
        for (int k = 0; k < n_cp; k++) begin
            case ($urandom_range(0, 10))
                0: text_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'h00
                                                                   : 8'($urandom_range(0, 127)));
                1, 2, 3: text_bytes.push_back(8'($urandom_range(0, 127)));
                4, 5: begin
                    text_bytes.push_back(8'($urandom_range(B_L2_MIN, B_L2_MAX)));
                    text_bytes.push_back(rand_cont(RNG_80_BF));
                end
                6, 7: begin
                    lead = 8'($urandom_range(B_L3_MIN, B_L3_MAX));
                    text_bytes.push_back(lead);
                    text_bytes.push_back(rand_cont(second_range(lead)));
                    text_bytes.push_back(rand_cont(RNG_80_BF));
                end
                8, 9: begin
                    lead = 8'($urandom_range(B_L4_MIN, B_L4_MAX));
                    text_bytes.push_back(lead);
                    text_bytes.push_back(rand_cont(second_range(lead)));
                    text_bytes.push_back(rand_cont(RNG_80_BF));
                    text_bytes.push_back(rand_cont(RNG_80_BF));
                end
                default: text_bytes.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        if (text_bytes.size() != 0 && $urandom_range(0, 3) == 0) begin
            pos = $urandom_range(0, text_bytes.size() - 1);
            if ($urandom_range(0, 1) == 1) text_bytes[pos] = 8'($urandom_range(0, 255));
            else void'(text_bytes.pop_back());
        end
        end_marker = (text_bytes.size() == 0) || ($urandom_range(0, 4) == 0);
        for (int i = 0; i < text_bytes.size(); i++) begin
            if ($urandom_range(0, 9) == 0)
                feed_q.push_back({8'($urandom_range(0, 255)), 1'b0, 1'b0});
            feed_q.push_back({text_bytes[i], 1'b1,
                              (i == text_bytes.size() - 1) && !end_marker});
        end
        if (end_marker) feed_q.push_back({8'($urandom_range(0, 255)), 1'b0, 1'b1});
    endtask

    initial begin
        int   stall;
        logic want;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = $urandom_range(0, m_gap_max);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (o_m_axis_tvalid !== 1'b1);
            if (verdict_q.size() == 0) begin
                $error("valid_res: no verdict expected, actual %0d", o_m_axis_tdata[0]);
                mismatches++;
            end else begin
                want = verdict_q.pop_front();
                if (o_m_axis_tdata[0] !== want) begin
                    $error("valid_res: expected %0d, actual %0d", want, o_m_axis_tdata[0]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int               target;
        logic [CFG_W-1:0] mb;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].verdict);

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                0: begin
                    write_reg(CFG_IDX_MAX_BYTES, '0);
                    write_reg(CFG_IDX_REJECT_NUL, '0);
                    s_gap_max = 0;
                    m_gap_max = 0;
                end
                1: begin
                    write_reg(CFG_IDX_MAX_BYTES, COUNT_TOP);
                    write_reg(CFG_IDX_REJECT_NUL, CFG_W'(1));
                    s_gap_max = 16;
                    m_gap_max = 16;
                end
                default: begin
                    case ($urandom_range(0, 5))
                        0: mb = '0;
                        1: mb = COUNT_TOP;
                        2: mb = MAX_BYTES_RST;
                        3: mb = CFG_W'($urandom_range(0, COUNT_TOP));
                        default: mb = CFG_W'($urandom_range(1, 12));
                    endcase
                    write_reg(CFG_IDX_MAX_BYTES, mb);
                    write_reg(CFG_IDX_REJECT_NUL, CFG_W'($urandom_range(0, 1)));
                    s_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
                    m_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
                end
            endcase
            target = string_items + PHASE_ITEMS;
            while (string_items < target) begin
                if (feed_q.size() == 0) build_string();
                send_item(feed_q.pop_front(), V_MODEL);
            end
        end
        while (feed_q.size() != 0) send_item(feed_q.pop_front(), V_MODEL);
        settle();

        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ utf8_string_validator_top.f @@
design/utf8v_pkg.sv
design/utf8v_front.sv
design/utf8v_queue.sv
design/utf8v_back.sv
design/utf8_string_validator_top.sv
design/utf8v_checker.sv
tb/tb.sv
